// ===== hw/rtl/cnrx_pkg.sv =====
// ----------------------------------------------------------------------------
// cnrx_pkg
// Shared widths, request codes and reset values for the CAN receive node
// demultiplexer.
// ----------------------------------------------------------------------------
package cnrx_pkg;

  localparam int BYTE_W      = 8;
  localparam int FRAME_BYTES = 8;
  localparam int ID_W        = 11;
  localparam int BC_W        = 4;
  localparam int NODE_W      = 8;
  localparam int KIND_W      = 2;
  localparam int CNT_OUT_W   = 7;

  localparam logic [KIND_W-1:0] KIND_FRAME = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAIN = 2'd2;

  localparam logic [ID_W-1:0] BASE_ID_RST = 11'h101;

endpackage

// ===== hw/rtl/cnrx_byte_ram.sv =====
// ----------------------------------------------------------------------------
// cnrx_byte_ram
// Byte store for all node buffers: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module cnrx_byte_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [cnrx_pkg::BYTE_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [cnrx_pkg::BYTE_W-1:0] rd_data
);
  import cnrx_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/cnrx_ctrl.sv =====
// ----------------------------------------------------------------------------
// cnrx_ctrl
// Request sequencer: appends frame bytes to the byte store one per cycle,
// answers length queries and streams drained bytes into the output register.
// Keeps the per-node byte counts and the base identifier register.
// ----------------------------------------------------------------------------
module cnrx_ctrl #(
  parameter int NODE_COUNT   = 4,
  parameter int BUFFER_DEPTH = 64,
  parameter int AW           = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cnrx_pkg::ID_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cnrx_pkg::KIND_W-1:0]    in_kind,
  input  logic [cnrx_pkg::ID_W-1:0]      in_frame_id,
  input  logic [cnrx_pkg::BC_W-1:0]      in_byte_count,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data0,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data1,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data2,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data3,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data4,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data5,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data6,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data7,
  input  logic [cnrx_pkg::NODE_W-1:0]    in_node,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cnrx_pkg::CNT_OUT_W-1:0] out_stored_count,
  output logic [cnrx_pkg::BYTE_W-1:0]    out_byte_value,
  output logic                           out_has_byte,
  output logic                           out_last,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_wa,
  output logic [cnrx_pkg::BYTE_W-1:0]    mem_wd,
  output logic                           mem_re,
  output logic [AW-1:0]                  mem_ra,
  input  logic [cnrx_pkg::BYTE_W-1:0]    mem_rd
);
  import cnrx_pkg::*;

  localparam int NI_W = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW   = $clog2(BUFFER_DEPTH + 1);

  typedef enum logic [2:0] {S_IDLE, S_WRITE, S_RESP, S_DRD, S_DOUT} state_t;

  state_t                 state_r;
  logic [ID_W-1:0]        base_id_r;
  logic [CW-1:0]          len_r [NODE_COUNT];
  logic [NI_W-1:0]        node_r;
  logic [BC_W-1:0]        left_r;
  logic [BYTE_W-1:0]      bytes_r [FRAME_BYTES];
  logic [CW-1:0]          ptr_r;
  logic [CW-1:0]          drain_len_r;
  logic [CNT_OUT_W-1:0]   resp_cnt_r;
  logic                   out_valid_r;
  logic [CNT_OUT_W-1:0]   out_cnt_r;
  logic [BYTE_W-1:0]      out_byte_r;
  logic                   out_has_r;
  logic                   out_last_r;

  logic                   in_fire;
  logic                   out_free;
  logic                   out_load;
  logic [ID_W:0]          id_diff;
  logic                   id_hit;
  logic [NI_W-1:0]        frame_node;
  logic                   node_ok;
  logic [NI_W-1:0]        req_node;
  logic [CW-1:0]          req_len;
  logic [CW+CNT_OUT_W-1:0] req_len_w;
  logic [CW+CNT_OUT_W-1:0] drain_len_w;
  logic [BC_W-1:0]        clip_cnt;
  logic [CW-1:0]          cur_len;
  logic                   wr_room;
  logic                   drain_last;
  logic [CW-1:0]          ptr_inc;
  logic [AW-1:0]          base_addr;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = out_free && ((state_r == S_RESP) || (state_r == S_DOUT));

  // Node of a frame: identifier minus base, in range only if no borrow.
  assign id_diff    = {1'b0, in_frame_id} - {1'b0, base_id_r};
  assign id_hit     = !id_diff[ID_W] && (id_diff[ID_W-1:0] < ID_W'(NODE_COUNT));
  assign frame_node = id_diff[NI_W-1:0];

  assign node_ok  = in_node < NODE_W'(NODE_COUNT);
  assign req_node = in_node[NI_W-1:0];
  assign req_len  = len_r[req_node];
  assign clip_cnt = (in_byte_count > BC_W'(FRAME_BYTES)) ? BC_W'(FRAME_BYTES)
                                                         : in_byte_count;

  // Reported counts are cut to the result field's width.
  assign req_len_w   = {{CNT_OUT_W{1'b0}}, req_len};
  assign drain_len_w = {{CNT_OUT_W{1'b0}}, drain_len_r};

  assign cur_len    = len_r[node_r];
  assign wr_room    = cur_len < CW'(BUFFER_DEPTH);
  assign ptr_inc    = CW'(ptr_r + 1'b1);
  assign drain_last = (ptr_inc == drain_len_r);
  assign base_addr  = AW'(AW'(node_r) * AW'(BUFFER_DEPTH));

  // Only one request is in flight, so a read never meets a pending write.
  assign mem_we = (state_r == S_WRITE) && wr_room;
  assign mem_wa = base_addr + AW'(cur_len);
  assign mem_wd = bytes_r[0];
  assign mem_re = (state_r == S_DRD) ||
                  ((state_r == S_DOUT) && out_free && !drain_last);
  assign mem_ra = base_addr + AW'((state_r == S_DOUT) ? ptr_inc : ptr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      base_id_r   <= BASE_ID_RST;
      for (int i = 0; i < NODE_COUNT; i++) begin
        len_r[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        base_id_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_kind)
              KIND_FRAME: begin
                if (id_hit && (clip_cnt != '0)) begin
                  state_r <= S_WRITE;
                end
              end
              KIND_QUERY: state_r <= S_RESP;
              KIND_DRAIN: begin
                if (node_ok && (req_len != '0)) begin
                  state_r <= S_DRD;
                end else begin
                  state_r <= S_RESP;
                end
              end
              default: ;
            endcase
          end
        end
        S_WRITE: begin
          // drop the byte once the buffer is full
          if (wr_room) begin
            len_r[node_r] <= CW'(cur_len + 1'b1);
          end
          if (left_r == BC_W'(1)) begin
            state_r <= S_IDLE;
          end
        end
        S_RESP: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_DRD: state_r <= S_DOUT;
        S_DOUT: begin
          if (out_free) begin
            if (drain_last) begin
              len_r[node_r] <= '0;
              state_r       <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          node_r      <= (in_kind == KIND_FRAME) ? frame_node : req_node;
          left_r      <= clip_cnt;
          ptr_r       <= '0;
          drain_len_r <= req_len;
          resp_cnt_r  <= ((in_kind == KIND_QUERY) && node_ok) ?
                         req_len_w[CNT_OUT_W-1:0] : '0;
          bytes_r[0]  <= in_data0;
          bytes_r[1]  <= in_data1;
          bytes_r[2]  <= in_data2;
          bytes_r[3]  <= in_data3;
          bytes_r[4]  <= in_data4;
          bytes_r[5]  <= in_data5;
          bytes_r[6]  <= in_data6;
          bytes_r[7]  <= in_data7;
        end
      end
      S_WRITE: begin
        // advance to the next frame byte
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          bytes_r[i] <= bytes_r[i+1];
        end
        left_r <= BC_W'(left_r - 1'b1);
      end
      S_RESP: begin
        if (out_free) begin
          out_cnt_r  <= resp_cnt_r;
          out_byte_r <= '0;
          out_has_r  <= 1'b0;
          out_last_r <= 1'b1;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          out_cnt_r  <= drain_len_w[CNT_OUT_W-1:0];
          out_byte_r <= mem_rd;
          out_has_r  <= 1'b1;
          out_last_r <= drain_last;
          ptr_r      <= ptr_inc;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_stored_count = out_cnt_r;
  assign out_byte_value   = out_byte_r;
  assign out_has_byte     = out_has_r;
  assign out_last         = out_last_r;

endmodule

// ===== hw/rtl/can_rx_node_demux_buffers_top.sv =====
// ----------------------------------------------------------------------------
// can_rx_node_demux_buffers_top
// CAN receive demultiplexer into per-node byte buffers.
//
// Input beats carry a request: a received frame (kind 0), a length query
// (kind 1) or a drain of one node's buffer (kind 2). A frame whose identifier
// lies in base_id .. base_id+NODE_COUNT-1 has up to eight bytes appended to
// that node's buffer, one byte per cycle; bytes beyond BUFFER_DEPTH are lost.
// A frame for a node holds off the next request until its bytes are written;
// any other frame, and an unused kind, returns to idle straight away.
// A query yields one result beat from the response state. A drain yields its
// first byte through the read and output states, then one byte a cycle while
// out_ready does not stall, paced by the single read port of the byte store;
// the buffer is emptied after the beat flagged last. Invalid nodes and empty
// drains give one beat with count zero. One request is handled at a time; a
// new one is taken while the last result still waits in the output register.
// A stall on out_ready holds the output register and the sequencer.
// The cfg channel writes base_id and is always ready. Reset empties every
// buffer and loads base_id with 0x101; no clearing pass is needed.
// ----------------------------------------------------------------------------
module can_rx_node_demux_buffers_top #(
  parameter int NODE_COUNT   = 4,
  parameter int BUFFER_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cnrx_pkg::ID_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [cnrx_pkg::KIND_W-1:0]    in_kind,
  input  logic [cnrx_pkg::ID_W-1:0]      in_frame_id,
  input  logic [cnrx_pkg::BC_W-1:0]      in_byte_count,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data0,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data1,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data2,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data3,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data4,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data5,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data6,
  input  logic [cnrx_pkg::BYTE_W-1:0]    in_data7,
  input  logic [cnrx_pkg::NODE_W-1:0]    in_node,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [cnrx_pkg::CNT_OUT_W-1:0] out_stored_count,
  output logic [cnrx_pkg::BYTE_W-1:0]    out_byte_value,
  output logic                           out_has_byte,
  output logic                           out_last
);
  import cnrx_pkg::*;

  localparam int MEM_DEPTH = NODE_COUNT * BUFFER_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [BYTE_W-1:0] mem_wd;
  logic              mem_re;
  logic [AW-1:0]     mem_ra;
  logic [BYTE_W-1:0] mem_rd;

  cnrx_ctrl #(
    .NODE_COUNT  (NODE_COUNT),
    .BUFFER_DEPTH(BUFFER_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_frame_id     (in_frame_id),
    .in_byte_count   (in_byte_count),
    .in_data0        (in_data0),
    .in_data1        (in_data1),
    .in_data2        (in_data2),
    .in_data3        (in_data3),
    .in_data4        (in_data4),
    .in_data5        (in_data5),
    .in_data6        (in_data6),
    .in_data7        (in_data7),
    .in_node         (in_node),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_stored_count(out_stored_count),
    .out_byte_value  (out_byte_value),
    .out_has_byte    (out_has_byte),
    .out_last        (out_last),
    .mem_we          (mem_we),
    .mem_wa          (mem_wa),
    .mem_wd          (mem_wd),
    .mem_re          (mem_re),
    .mem_ra          (mem_ra),
    .mem_rd          (mem_rd)
  );

  cnrx_byte_ram #(
    .DEPTH(MEM_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_wa),
    .wr_data(mem_wd),
    .rd_en  (mem_re),
    .rd_addr(mem_ra),
    .rd_data(mem_rd)
  );

endmodule

// ===== hw/rtl/cnrx_checker.sv =====
// ----------------------------------------------------------------------------
// cnrx_checker
// Port-level checks on the result channel of the node demultiplexer.
// ----------------------------------------------------------------------------
module cnrx_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [cnrx_pkg::CNT_OUT_W-1:0] out_stored_count,
  input logic [cnrx_pkg::BYTE_W-1:0]    out_byte_value,
  input logic                           out_has_byte,
  input logic                           out_last
);
  import cnrx_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_stored_count) &&
      $stable(out_byte_value) && $stable(out_has_byte) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // a beat without a byte always closes its request
  a_nobyte_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_byte |-> out_last && (out_byte_value == '0))
    else $error("byteless beat not last or carries data");

  // within one drain the reported count stays fixed
  a_drain_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_has_byte && !out_last ##1 out_valid |->
      out_has_byte && (out_stored_count == $past(out_stored_count)))
    else $error("drain count changed mid-stream");

endmodule

bind can_rx_node_demux_buffers_top cnrx_checker u_cnrx_checker (.*);
